>>> rtl/bqt_pkg.sv
// Shared types, constants and helpers for the binary image quadtree encoder.
// Used by bqt_ctrl, bqt_datapath and binary_image_quadtree_encoder.
`timescale 1ns / 1ps

package bqt_pkg;

  localparam int MAX_SIDE   = 8;
  localparam int DIM_W      = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int COUNT_W    = 6;
  localparam int DEPTH_W    = 2;
  localparam int PATH_W     = 6;
  localparam int COORD_W    = 3;
  localparam int NUM_WORDS  = 16;  // 2x2 quads of the 8x8 store, Morton order
  localparam int WADDR_W    = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_COLS = 2'd1;

  localparam logic KIND_SUMMARY = 1'b0;
  localparam logic KIND_BLOCK   = 1'b1;

  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(MAX_SIDE);

  typedef struct packed {
    logic load;        // take the pixel on the input port
    logic sweep_init;  // reset the quadrant flag sweep
    logic sweep_step;  // fold one quad into the quadrant flags
    logic walk_init;   // put the cursor on the root
    logic walk_step;   // visit one node
    logic emit_on;     // blocks found in this walk go out
    logic summary;     // send the count item
  } bqt_cmd_t;

  typedef struct packed {
    logic pix_last;    // next pixel completes the image
    logic sweep_last;  // sweep is on its final quad
    logic walk_last;   // this visit ends the walk
    logic none_found;  // image has no all-ones block
  } bqt_status_t;

  // Clamp a dimension register to 1..MAX_SIDE.
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] d;
    d = v;
    if (v == '0) d = DIM_W'(1);
    else if (v > DIM_W'(MAX_SIDE)) d = DIM_W'(MAX_SIDE);
    return d;
  endfunction

endpackage

>>> rtl/bqt_ctrl.sv
// Sequencer for the quadtree encoder: load, flag sweep, count walk, summary, emit walk.
// Depends on bqt_pkg for the command and status structs.
`timescale 1ns / 1ps

module bqt_ctrl import bqt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  bqt_status_t status,
  output bqt_cmd_t    cmd,
  output logic        busy
);

  typedef enum logic [2:0] {
    S_LOAD, S_SWEEP, S_COUNT, S_SUMMARY, S_EMIT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_LOAD: begin
        cmd.load = start;
        if (start && status.pix_last) begin
          cmd.sweep_init = 1'b1;
          state_nxt      = S_SWEEP;
        end
      end
      S_SWEEP: begin
        cmd.sweep_step = 1'b1;
        if (status.sweep_last) begin
          cmd.walk_init = 1'b1;
          state_nxt     = S_COUNT;
        end
      end
      S_COUNT: begin
        cmd.walk_step = 1'b1;
        if (status.walk_last) state_nxt = S_SUMMARY;
      end
      S_SUMMARY: begin
        cmd.summary   = 1'b1;
        cmd.walk_init = 1'b1;
        state_nxt     = status.none_found ? S_LOAD : S_EMIT;
      end
      S_EMIT: begin
        cmd.walk_step = 1'b1;
        cmd.emit_on   = 1'b1;
        if (status.walk_last) state_nxt = S_LOAD;
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  assign busy = (state_r != S_LOAD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> rtl/bqt_datapath.sv
// Datapath of the quadtree encoder: pixel store, dimension registers, quadrant
// flags, walk cursor and result registers. Depends on bqt_pkg.
`timescale 1ns / 1ps

module bqt_datapath import bqt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bqt_cmd_t             cmd,
  output bqt_status_t          status,
  input  logic                 pixel,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  output logic                 out_valid,
  output logic                 out_item_kind,
  output logic [COUNT_W-1:0]   out_block_count,
  output logic [DEPTH_W-1:0]   out_block_depth,
  output logic [PATH_W-1:0]    out_block_path,
  output logic                 out_last_result
);

  logic [DIM_W-1:0]   rows_r, cols_r;
  logic [DIM_W-1:0]   rows_eff, cols_eff, big;
  logic [COORD_W-1:0] row_r, col_r;
  logic               row_end, col_end;
  logic [3:0]         store_r [NUM_WORDS];
  logic [WADDR_W-1:0] wr_addr;

  logic [WADDR_W-1:0] sweep_cnt_r;
  logic [3:0]         q_all1_r, q_any1_r;

  logic [1:0]         lvl_r, lvl_nxt, offset;
  logic [3:1][1:0]    dig_r, dig_nxt;
  logic [COUNT_W-1:0] ones_r, emit_k_r;

  logic [WADDR_W-1:0] rd_addr;
  logic [3:0]         word;
  logic               all1, zero, uniform, carry;
  logic [PATH_W-1:0]  path;

  assign rows_eff = eff_dim(rows_r);
  assign cols_eff = eff_dim(cols_r);
  assign big      = (rows_eff > cols_eff) ? rows_eff : cols_eff;
  // Root sits this many levels below the full 8x8 store.
  assign offset   = (big <= DIM_W'(2)) ? 2'd2 : (big <= DIM_W'(4)) ? 2'd1 : 2'd0;

  assign col_end  = ({1'b0, col_r} == cols_eff - DIM_W'(1));
  assign row_end  = ({1'b0, row_r} == rows_eff - DIM_W'(1));
  assign wr_addr  = {row_r[2], col_r[2], row_r[1], col_r[1]};

  // Read one quad; bits outside the image read as zero.
  assign rd_addr = cmd.sweep_step ? sweep_cnt_r : {dig_r[1], dig_r[2]};
  always_comb begin
    for (int b = 0; b < 4; b++) begin
      word[b] = store_r[rd_addr][b]
        & ({1'b0, rd_addr[3], rd_addr[1], b[1]} < rows_eff)
        & ({1'b0, rd_addr[2], rd_addr[0], b[0]} < cols_eff);
    end
  end

  // Node classification at the cursor.
  always_comb begin
    case (lvl_r)
      2'd0: begin
        all1 = &q_all1_r;
        zero = ~|q_any1_r;
      end
      2'd1: begin
        all1 = q_all1_r[dig_r[1]];
        zero = ~q_any1_r[dig_r[1]];
      end
      2'd2: begin
        all1 = &word;
        zero = ~|word;
      end
      default: begin
        all1 = word[dig_r[3]];
        zero = ~word[dig_r[3]];
      end
    endcase
    uniform = all1 | zero;
  end

  // Preorder advance: descend into a mixed node, else step to the next sibling,
  // climbing while the digit wraps. Climbing past the root ends the walk.
  always_comb begin
    dig_nxt = dig_r;
    lvl_nxt = lvl_r;
    carry   = 1'b0;
    if (!uniform) begin
      lvl_nxt = lvl_r + 2'd1;
      for (int j = 1; j <= 3; j++) begin
        if (j == int'(lvl_r) + 1) dig_nxt[j] = 2'd0;
      end
    end else begin
      carry = 1'b1;
      for (int j = 3; j >= 1; j--) begin
        if (carry && (j <= int'(lvl_r)) && (j > int'(offset))) begin
          if (dig_r[j] == 2'd3) begin
            dig_nxt[j] = 2'd0;
          end else begin
            dig_nxt[j] = dig_r[j] + 2'd1;
            lvl_nxt    = 2'(j);
            carry      = 1'b0;
          end
        end
      end
    end
  end

  always_comb begin
    case (lvl_r)
      2'd0:    path = '0;
      2'd1:    path = {4'b0, dig_r[1]};
      2'd2:    path = {2'b0, dig_r[1], dig_r[2]};
      default: path = {dig_r[1], dig_r[2], dig_r[3]};
    endcase
  end

  assign status.pix_last   = row_end && col_end;
  assign status.sweep_last = (sweep_cnt_r == WADDR_W'(NUM_WORDS - 1));
  assign status.walk_last  = carry;
  assign status.none_found = (ones_r == '0);

  // Store: written only inside the image, so no clearing is needed.
  always_ff @(posedge clk) begin
    if (cmd.load) store_r[wr_addr][{row_r[0], col_r[0]}] <= pixel;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= DIM_RESET;
      cols_r <= DIM_RESET;
      row_r  <= '0;
      col_r  <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_IMAGE_ROWS) rows_r <= cfg_data;
        if (cfg_index == CFG_IMAGE_COLS) cols_r <= cfg_data;
        // drop any partly loaded image on a known register
        if (cfg_index == CFG_IMAGE_ROWS || cfg_index == CFG_IMAGE_COLS) begin
          row_r <= '0;
          col_r <= '0;
        end
      end else if (cmd.load) begin
        if (col_end) begin
          col_r <= '0;
          row_r <= row_end ? '0 : row_r + COORD_W'(1);
        end else begin
          col_r <= col_r + COORD_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_cnt_r <= '0;
      q_all1_r    <= '1;
      q_any1_r    <= '0;
      lvl_r       <= '0;
      dig_r       <= '0;
      ones_r      <= '0;
      emit_k_r    <= '0;
      out_valid   <= 1'b0;
    end else begin
      out_valid <= cmd.summary | (cmd.walk_step & cmd.emit_on & all1);
      if (cmd.sweep_init) begin
        sweep_cnt_r <= '0;
        q_all1_r    <= '1;
        q_any1_r    <= '0;
        ones_r      <= '0;
      end
      if (cmd.sweep_step) begin
        sweep_cnt_r <= sweep_cnt_r + WADDR_W'(1);
        q_all1_r[sweep_cnt_r[3:2]] <= q_all1_r[sweep_cnt_r[3:2]] & (&word);
        q_any1_r[sweep_cnt_r[3:2]] <= q_any1_r[sweep_cnt_r[3:2]] | (|word);
      end
      if (cmd.walk_init) begin
        lvl_r <= offset;
        dig_r <= '0;
      end
      if (cmd.summary) begin
        emit_k_r        <= '0;
        out_item_kind   <= KIND_SUMMARY;
        out_block_count <= ones_r;
        out_block_depth <= '0;
        out_block_path  <= '0;
        out_last_result <= (ones_r == '0);
      end
      if (cmd.walk_step) begin
        lvl_r <= lvl_nxt;
        dig_r <= dig_nxt;
        if (all1) begin
          if (cmd.emit_on) begin
            emit_k_r        <= emit_k_r + COUNT_W'(1);
            out_item_kind   <= KIND_BLOCK;
            out_block_count <= '0;
            out_block_depth <= lvl_r - offset;
            out_block_path  <= path;
            out_last_result <= (emit_k_r == ones_r - COUNT_W'(1));
          end else begin
            ones_r <= ones_r + COUNT_W'(1);
          end
        end
      end
    end
  end

endmodule

>>> rtl/binary_image_quadtree_encoder.sv
// Top level of the binary image quadtree encoder: controller plus datapath.
// Depends on bqt_pkg, bqt_ctrl and bqt_datapath.
`timescale 1ns / 1ps
//
//  channel   ports                                   transaction when
//  --------  --------------------------------------  ---------------------------
//  pixel in  start, busy, in_pixel                   start high, busy low
//  result    out_valid, out_item_kind, out_block_*,  out_valid high (one cycle)
//            out_last_result
//  config    cfg_valid, cfg_ready, cfg_index,        cfg_valid and cfg_ready high
//            cfg_data
//
// Pixels are taken one per cycle while busy is low. The final pixel of an image
// starts a sweep over the 16 quads of the store that builds the quadrant flags,
// then two preorder walks of N nodes each (N is at most 85 for an 8x8 store), one
// visit per cycle: a counting walk, the count item, and the emitting walk. The
// emitting walk is skipped when the image has no all-ones block.
// Synchronous active-low reset sets both dimensions to 8 and restarts loading;
// the store needs no clearing, since cells outside the image are masked on read.
// The receiver cannot stall: each result is shown for exactly one cycle.
// cfg_ready is always high; write configuration only while busy is low.

module binary_image_quadtree_encoder import bqt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_pixel,
  output logic                 out_valid,
  output logic                 out_item_kind,
  output logic [COUNT_W-1:0]   out_block_count,
  output logic [DEPTH_W-1:0]   out_block_depth,
  output logic [PATH_W-1:0]    out_block_path,
  output logic                 out_last_result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data
);

  bqt_cmd_t    cmd;
  bqt_status_t status;

  // Registers accept every write; the sequencer never blocks this port.
  assign cfg_ready = 1'b1;

  bqt_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  bqt_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .pixel           (in_pixel),
    .cfg_we          (cfg_valid & cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_item_kind   (out_item_kind),
    .out_block_count (out_block_count),
    .out_block_depth (out_block_depth),
    .out_block_path  (out_block_path),
    .out_last_result (out_last_result)
  );

endmodule
